// ----- hw/rtl/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the SHA-256 core.
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  valid_bytes;
        logic        last_word;
    } t_in_word;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  digest_index;
        logic        digest_done;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_ROUND,
        S_UPDATE,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        PK_NONE,
        PK_MARK,
        PK_ZERO,
        PK_LENLO,
        PK_FINISH
    } t_pad;

    // control from sequencer to round datapath
    typedef struct packed {
        logic        load_en;
        logic [2:0]  load_idx;
        logic [31:0] load_data;
        logic        round_en;
        logic        from_mem;
        logic [31:0] k;
        logic [31:0] w_mem;
    } t_rnd_ctl;

    typedef logic [7:0][31:0] t_vars;

    localparam logic [31:0] PAD_MARK = 32'h8000_0000;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_ROM [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// ----- hw/rtl/sha_ram.sv -----
// ----------------------------------------------------------------------------
// sha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- hw/rtl/sha_round.sv -----
// ----------------------------------------------------------------------------
// sha_round
// Working variables a..h, 16-word schedule window and one round per cycle while round_en is set.
// ----------------------------------------------------------------------------
module sha_round (
    input  logic              i_clk,
    input  sha_pkg::t_rnd_ctl i_ctl,
    output sha_pkg::t_vars    o_vars
);
    import sha_pkg::*;

    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [31:0] w_cur;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] mj;

    always_comb begin
        w_cur = i_ctl.from_mem ? i_ctl.w_mem
              : r_w[0] + ssig0(r_w[1]) + r_w[9] + ssig1(r_w[14]);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1 = r_v[7] + bsig1(r_v[4]) + ch + i_ctl.k + w_cur;
        t2 = bsig0(r_v[0]) + mj;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_en) begin
            r_v[i_ctl.load_idx] <= i_ctl.load_data;
        end else if (i_ctl.round_en) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        if (i_ctl.round_en) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_cur;
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            o_vars[i] = r_v[i];
        end
    end

endmodule

// ----- hw/rtl/sha256_hash_core.sv -----
// ----------------------------------------------------------------------------
// sha256_hash_core
// Streaming SHA-256 over big-endian 32-bit words with built-in padding.
// ----------------------------------------------------------------------------
// Message words are written straight into a 16-entry block RAM; the eight
// hash words live in an 8-entry RAM whose entries read as the standard
// initial values until written in the current message. Every sixteenth
// word (including padding words) starts a block: load a..h from the hash
// RAM, run the 64 rounds, one compression round per cycle, then
// read-add-writeback the eight hash words; all the while the input is
// stalled. The last word is followed by padding words, one per cycle,
// giving one or two more blocks, then the eight digest words leave through
// an output register while the output is not stalled; a word is loaded
// only after the previous one has left the register. digest_done marks
// the word with index 7. The next message may start as soon as the last
// digest word sits in the output register.
// ----------------------------------------------------------------------------
module sha256_hash_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sha_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sha_pkg::t_out_word o_out_data
);
    import sha_pkg::*;

    t_state      r_state, n_state;
    t_pad        r_pad;
    logic [3:0]  r_pos;
    logic [63:0] r_len;
    logic [6:0]  r_cnt;
    logic        r_ph;
    logic [7:0]  r_hvalid;
    logic [2:0]  r_hraddr_q;
    logic        r_hvalid_q;
    logic        r_ovalid;
    t_out_word   r_odata;

    logic        accept;
    logic        push_en;
    logic [31:0] push_word;
    t_pad        pad_next;
    logic [31:0] last_word_pad;
    logic [2:0]  vb_sat;

    logic        wr_unused;
    logic [3:0]  w_raddr;
    logic [31:0] w_rdata;

    logic        h_we;
    logic [2:0]  h_waddr;
    logic [31:0] h_wdata;
    logic [2:0]  h_raddr;
    logic [31:0] h_q;
    logic [31:0] h_rdata;

    t_rnd_ctl    rnd_ctl;
    t_vars       vars;

    assign wr_unused = 1'b0;
    assign accept    = (r_state == S_IDLE) && i_in_valid;
    assign vb_sat    = (i_in_data.valid_bytes > 3'd4) ? 3'd4 : i_in_data.valid_bytes;

    // last word: keep valid bytes, drop the rest, place the 0x80 marker if room
    always_comb begin
        unique case (vb_sat)
            3'd0:    last_word_pad = PAD_MARK;
            3'd1:    last_word_pad = {i_in_data.data_word[31:24], 24'h80_0000};
            3'd2:    last_word_pad = {i_in_data.data_word[31:16], 16'h8000};
            3'd3:    last_word_pad = {i_in_data.data_word[31:8], 8'h80};
            default: last_word_pad = i_in_data.data_word;
        endcase
    end

    // word pushed into the block RAM this cycle
    always_comb begin
        push_en   = 1'b0;
        push_word = i_in_data.data_word;
        pad_next  = r_pad;
        if (r_state == S_IDLE) begin
            push_en = accept;
            if (i_in_data.last_word) begin
                push_word = last_word_pad;
                pad_next  = (vb_sat == 3'd4) ? PK_MARK : PK_ZERO;
            end
        end else if (r_state == S_PAD) begin
            push_en = 1'b1;
            unique case (r_pad)
                PK_MARK: begin
                    push_word = PAD_MARK;
                    pad_next  = PK_ZERO;
                end
                PK_ZERO: begin
                    if (r_pos == 4'd14) begin
                        push_word = r_len[63:32];
                        pad_next  = PK_LENLO;
                    end else begin
                        push_word = '0;
                    end
                end
                PK_LENLO: begin
                    push_word = r_len[31:0];
                    pad_next  = PK_FINISH;
                end
                default: begin
                    push_en   = 1'b0;
                    push_word = '0;
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_pos == 4'd15) begin
                        n_state = S_LOAD;
                    end else if (i_in_data.last_word) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (r_pos == 4'd15) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (r_cnt == 7'd8) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                if (r_cnt == 7'd63) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (r_cnt == 7'd8) begin
                    unique case (r_pad)
                        PK_FINISH: n_state = S_OUT;
                        PK_NONE:   n_state = S_IDLE;
                        default:   n_state = S_PAD;
                    endcase
                end
            end
            S_OUT: begin
                if (r_ph && r_cnt[2:0] == 3'd7) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory and datapath controls
    always_comb begin
        w_raddr = (r_state == S_ROUND) ? r_cnt[3:0] + 4'd1 : 4'd0;
        h_raddr = r_cnt[2:0];
        h_we    = (r_state == S_UPDATE) && (r_cnt != 7'd0);
        h_waddr = 3'(r_cnt - 7'd1);
        h_wdata = h_rdata + vars[h_waddr];

        rnd_ctl.load_en   = (r_state == S_LOAD) && (r_cnt != 7'd0);
        rnd_ctl.load_idx  = 3'(r_cnt - 7'd1);
        rnd_ctl.load_data = h_rdata;
        rnd_ctl.round_en  = (r_state == S_ROUND);
        rnd_ctl.from_mem  = (r_cnt < 7'd16);
        rnd_ctl.k         = K_ROM[r_cnt[5:0]];
        rnd_ctl.w_mem     = w_rdata;
    end

    // untouched hash entries read as the initial values
    assign h_rdata = r_hvalid_q ? h_q : IV[r_hraddr_q];

    sha_ram #(.WIDTH(32), .DEPTH(16)) u_block_ram (
        .i_clk   (i_clk),
        .i_we    (push_en),
        .i_waddr (r_pos),
        .i_wdata (push_word),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    sha_ram #(.WIDTH(32), .DEPTH(8)) u_hash_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_q)
    );

    sha_round u_round (
        .i_clk (i_clk),
        .i_ctl (rnd_ctl),
        .o_vars(vars)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        r_hraddr_q <= h_raddr;
        r_hvalid_q <= r_hvalid[h_raddr] | wr_unused;
        if (r_state == S_OUT && r_ph) begin
            r_odata.digest_word  <= h_rdata;
            r_odata.digest_index <= r_cnt[2:0];
            r_odata.digest_done  <= (r_cnt[2:0] == 3'd7);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pad    <= PK_NONE;
            r_pos    <= '0;
            r_len    <= '0;
            r_cnt    <= '0;
            r_ph     <= 1'b0;
            r_hvalid <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (push_en) begin
                r_pos <= r_pos + 4'd1;
                r_pad <= pad_next;
            end
            if (accept) begin
                if (i_in_data.last_word) begin
                    r_len <= r_len + {58'd0, vb_sat, 3'd0};
                end else begin
                    r_len <= r_len + 64'd32;
                end
            end
            if (h_we) begin
                r_hvalid[h_waddr] <= 1'b1;
            end

            if (o_out_valid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_LOAD, S_ROUND, S_UPDATE: begin
                    r_cnt <= (n_state != r_state) ? 7'd0 : r_cnt + 7'd1;
                end
                S_OUT: begin
                    if (!r_ph) begin
                        if (!r_ovalid) begin
                            r_ph <= 1'b1;
                        end
                    end else begin
                        r_ph     <= 1'b0;
                        r_ovalid <= 1'b1;
                        if (r_cnt[2:0] == 3'd7) begin
                            // digest fully read: start a fresh message
                            r_cnt    <= '0;
                            r_hvalid <= '0;
                            r_len    <= '0;
                            r_pos    <= '0;
                            r_pad    <= PK_NONE;
                        end else begin
                            r_cnt    <= r_cnt + 7'd1;
                        end
                    end
                end
                default: r_cnt <= '0;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule
